### sv/tile_mean_threshold_macros.svh
// ----------------------------------------------------------------------------
// Tile mean threshold: assertion macros
// Shared property shapes for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef TILE_MEAN_THRESHOLD_MACROS_SVH
`define TILE_MEAN_THRESHOLD_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define TMT_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("tile_mean_threshold: check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define TMT_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("tile_mean_threshold: check failed");

`endif

### sv/tmt_pkg.sv
// ----------------------------------------------------------------------------
// Tile mean threshold: package
// Field widths, register indexes, reset values and fixed constants.
// ----------------------------------------------------------------------------
package tmt_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int START_W    = 10;
    localparam int LEN_W      = 5;
    localparam int LEVEL_W    = 8;
    localparam int SUM_W      = 16;
    localparam int TS_W       = 5;
    localparam int THR_W      = 8;
    localparam int WID_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Tile descriptor queue depth, a power of two.
    localparam int DESC_DEPTH = 4;

    localparam logic [LEVEL_W-1:0] PASS_LEVEL = 8'd255;
    localparam logic [LEVEL_W-1:0] FAIL_LEVEL = 8'd0;

    localparam logic [TS_W-1:0]  RST_TILE_SIZE = 5'd3;
    localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd100;
    localparam logic [ROW_W-1:0] RST_FIRST_ROW = 12'd100;
    localparam logic [WID_W-1:0] RST_WIDTH     = 11'd224;
    localparam logic [ROW_W-1:0] RST_HEIGHT    = 12'd224;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_SIZE      = 3'd0,
        CFG_MEAN_THRESHOLD = 3'd1,
        CFG_FIRST_ROW      = 3'd2,
        CFG_IMAGE_WIDTH    = 3'd3,
        CFG_IMAGE_HEIGHT   = 3'd4
    } t_cfg_reg;

endpackage

### sv/tmt_ram.sv
// ----------------------------------------------------------------------------
// Tile mean threshold: generic RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
module tmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tile_mean_threshold.sv
// ----------------------------------------------------------------------------
// Tile mean threshold
// Block-mean binarization of an 8-bit grey raster stream over square tiles.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on i_valid / o_stall / i_pixel, one request per
// cycle when the block is not stalling. Each column keeps its sum over the
// current band of rows in a single-port-pair RAM, read when a pixel is
// accepted and written back in the next cycle, with a forward for
// back-to-back hits on one column. When the last pixel of a tile is accepted,
// the tile passes if sum >= threshold * pixel count, and one span request per
// tile row leaves on o_valid / i_stall, the last one flagged by o_last. The
// first span passes the read-modify-write stage, the compare stage, the
// descriptor queue and the output register; spans then leave at one per
// cycle while i_stall is low. Pixels are taken at one per cycle while o_stall
// is low; the input stalls during realignment and when the four-entry tile
// descriptor queue could overflow, which happens when the receiver stalls or
// when tiles have more rows than columns. A write to tile_size or image_width
// realigns the tile position in $clog2(MAX_WIDTH) remainder steps and up to
// MAX_TILE - 1 column reads; other registers act at once. Reset restores the
// register defaults, starts a new frame at row 0 and empties the pipeline and
// queue. While the receiver stalls, the output request is held steady.
// ----------------------------------------------------------------------------
`include "tile_mean_threshold_macros.svh"

module tile_mean_threshold #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_TILE  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [tmt_pkg::PIX_W-1:0]        i_pixel,
    // span channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tmt_pkg::ROW_W-1:0]        o_out_row,
    output logic [tmt_pkg::START_W-1:0]      o_span_start,
    output logic [tmt_pkg::LEN_W-1:0]        o_span_length,
    output logic [tmt_pkg::LEVEL_W-1:0]      o_level,
    output logic                             o_last,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tmt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import tmt_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);       // column index
    localparam int WW   = $clog2(MAX_WIDTH + 1);   // width value
    localparam int RW   = $clog2(MAX_TILE);        // position inside a tile
    localparam int TW   = $clog2(MAX_TILE + 1);    // tile edge value
    localparam int AW   = SUM_W + $clog2(MAX_TILE);
    localparam int LW   = 2 * TW;
    localparam int PW   = THR_W + LW;
    localparam int CMPW = (AW > PW) ? AW : PW;
    localparam int DCW  = $clog2(CW);
    localparam int FAW  = $clog2(DESC_DEPTH);
    localparam int FCW  = $clog2(DESC_DEPTH + 1);

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_SUM
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0]   row0;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic [TW-1:0]      rows;
        logic               pass;
    } t_desc;

    // Configuration registers.
    logic [TS_W-1:0]  r_tile_size;
    logic [THR_W-1:0] r_thr;
    logic [ROW_W-1:0] r_first_row;
    logic [WID_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;

    logic [TW-1:0]    ts_eff;
    logic [WW-1:0]    w_eff;
    logic [CW-1:0]    w_m1;
    logic [ROW_W-1:0] h_m1;

    // Frame position and realignment state.
    t_state           r_state, n_state;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_tcol, n_tcol;
    logic [ROW_W-1:0] r_row, n_row;
    logic [RW-1:0]    r_rib, n_rib;
    logic [ROW_W-1:0] r_bsr, n_bsr;
    logic [DCW-1:0]   r_div_cnt, n_div_cnt;
    logic [TW-1:0]    r_rem, n_rem;
    logic [RW-1:0]    r_sum_cnt, n_sum_cnt;
    logic             r_rd_pend, n_rd_pend;
    logic [AW-1:0]    r_acc, n_acc;

    logic             in_acc;
    logic             cfg_geom;
    logic [CW-1:0]    col_clamp;
    logic             row_end, row_last, band_end, tile_last, tile_end;
    logic [TW:0]      rem_sh;
    logic [TW-1:0]    rem_step;
    logic             sum_issue;
    logic [CW-1:0]    sum_addr;

    // RAM ports.
    logic [CW-1:0]    ram_raddr;
    logic [SUM_W-1:0] ram_rdata;

    // Read-modify-write stage.
    logic             r_s1_valid, r_s1_te;
    logic [CW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_first, r_s1_tstart, r_s1_fwd;
    logic [CW-1:0]    r_s1_start;
    logic [TW-1:0]    r_s1_len, r_s1_rows;
    logic [ROW_W-1:0] r_s1_row0;
    logic [SUM_W-1:0] r_wq;
    logic [SUM_W-1:0] s1_old, s1_new;
    logic [AW-1:0]    s1_sum;

    // Compare stage.
    logic             r_s2_valid;
    logic [AW-1:0]    r_s2_sum;
    logic [LW-1:0]    r_s2_lr;
    logic [CW-1:0]    r_s2_start;
    logic [TW-1:0]    r_s2_len, r_s2_rows;
    logic [ROW_W-1:0] r_s2_row0;
    logic             s2_pass;
    t_desc            s2_desc;

    // Descriptor queue and span emitter.
    t_desc            r_fifo [DESC_DEPTH];
    logic [FAW-1:0]   r_wp, r_rp;
    logic [FCW-1:0]   r_fcnt;
    logic [RW-1:0]    r_em_r;
    t_desc            head;
    logic             out_free, em_go, em_last, pop;
    logic [ROW_W-1:0] em_row;

    logic                r_o_valid;
    logic [ROW_W-1:0]    r_o_row;
    logic [START_W-1:0]  r_o_start;
    logic [LEN_W-1:0]    r_o_len;
    logic [LEVEL_W-1:0]  r_o_level;
    logic                r_o_last;

    // ------------------------------------------------------------------
    // Effective geometry: zero acts as one, large values clip to the maxima.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_tile_size == '0) begin
            ts_eff = TW'(1);
        end else if (32'(r_tile_size) > MAX_TILE) begin
            ts_eff = TW'(MAX_TILE);
        end else begin
            ts_eff = TW'(r_tile_size);
        end
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        w_m1 = CW'(w_eff - WW'(1));
        h_m1 = (r_height == '0) ? '0 : r_height - ROW_W'(1);
    end

    // ------------------------------------------------------------------
    // Configuration writes; the port never back-pressures.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_geom    = i_cfg_valid &&
                         ((t_cfg_reg'(i_cfg_index) == CFG_TILE_SIZE) ||
                          (t_cfg_reg'(i_cfg_index) == CFG_IMAGE_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size <= RST_TILE_SIZE;
            r_thr       <= RST_THRESHOLD;
            r_first_row <= RST_FIRST_ROW;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TILE_SIZE:      r_tile_size <= i_cfg_data[TS_W-1:0];
                CFG_MEAN_THRESHOLD: r_thr       <= i_cfg_data[THR_W-1:0];
                CFG_FIRST_ROW:      r_first_row <= i_cfg_data[ROW_W-1:0];
                CFG_IMAGE_WIDTH:    r_width     <= i_cfg_data[WID_W-1:0];
                CFG_IMAGE_HEIGHT:   r_height    <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: position tracking and the tile-end decision.
    // ------------------------------------------------------------------
    assign o_stall = (r_state != S_RUN) ||
                     (32'(r_fcnt) + 32'(r_s1_te) + 32'(r_s2_valid) >= DESC_DEPTH);
    assign in_acc  = i_valid && !o_stall;

    assign row_end   = (r_col >= w_m1);
    assign row_last  = (r_row >= h_m1);
    assign band_end  = (32'(r_rib) + 1 >= 32'(ts_eff)) || row_last;
    assign tile_last = (32'(r_tcol) + 1 >= 32'(ts_eff));
    assign tile_end  = band_end && (row_end || tile_last);

    // Realignment after a geometry write: clamp the column to the new width,
    // find its offset inside a tile one bit per cycle, then re-add the sums
    // of the tile's columns already seen in this row.
    assign col_clamp = (r_col > w_m1) ? w_m1 : r_col;
    assign rem_sh    = {r_rem, col_clamp[r_div_cnt]};
    assign rem_step  = (rem_sh >= {1'b0, ts_eff}) ? TW'(rem_sh - {1'b0, ts_eff})
                                                  : TW'(rem_sh);
    assign sum_issue = (r_sum_cnt < r_tcol);
    assign sum_addr  = r_col - CW'(r_tcol) + CW'(r_sum_cnt);

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_tcol    = r_tcol;
        n_row     = r_row;
        n_rib     = r_rib;
        n_bsr     = r_bsr;
        n_div_cnt = r_div_cnt;
        n_rem     = r_rem;
        n_sum_cnt = r_sum_cnt;
        n_rd_pend = 1'b0;
        n_acc     = r_acc;
        unique case (r_state)
            S_RUN: begin
                if (r_s1_valid) begin
                    n_acc = s1_sum;
                end
                if (in_acc) begin
                    if (row_end) begin
                        n_col  = '0;
                        n_tcol = '0;
                        if (row_last) begin
                            n_row = '0;
                            n_rib = '0;
                            n_bsr = '0;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                            if (band_end) begin
                                n_rib = '0;
                                n_bsr = r_row + ROW_W'(1);
                            end else begin
                                n_rib = r_rib + RW'(1);
                            end
                        end
                    end else begin
                        n_col  = r_col + CW'(1);
                        n_tcol = tile_last ? '0 : r_tcol + RW'(1);
                    end
                end
            end
            S_DIV: begin
                n_rem     = rem_step;
                n_div_cnt = r_div_cnt - DCW'(1);
                if (r_div_cnt == '0) begin
                    n_col     = col_clamp;
                    n_tcol    = RW'(rem_step);
                    n_acc     = '0;
                    n_sum_cnt = '0;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                n_rd_pend = sum_issue;
                if (sum_issue) begin
                    n_sum_cnt = r_sum_cnt + RW'(1);
                end
                if (r_rd_pend) begin
                    n_acc = r_acc + AW'(ram_rdata);
                end
                if (!sum_issue && !r_rd_pend) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
        if (cfg_geom) begin
            n_state   = S_DIV;
            n_div_cnt = DCW'(CW - 1);
            n_rem     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_col     <= '0;
            r_tcol    <= '0;
            r_row     <= '0;
            r_rib     <= '0;
            r_bsr     <= '0;
            r_div_cnt <= '0;
            r_rem     <= '0;
            r_sum_cnt <= '0;
            r_rd_pend <= 1'b0;
            r_acc     <= '0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_tcol    <= n_tcol;
            r_row     <= n_row;
            r_rib     <= n_rib;
            r_bsr     <= n_bsr;
            r_div_cnt <= n_div_cnt;
            r_rem     <= n_rem;
            r_sum_cnt <= n_sum_cnt;
            r_rd_pend <= n_rd_pend;
            r_acc     <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // Column sum memory: read at accept or during realignment, modify and write back in the next cycle.
    // ------------------------------------------------------------------
    assign ram_raddr = (r_state == S_SUM) ? sum_addr : r_col;

    tmt_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_new),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The RAM returns old data when the previous pixel wrote the same column
    // (single-column images), so that value comes from the write-back register.
    assign s1_old = r_s1_fwd ? r_wq : ram_rdata;
    assign s1_new = r_s1_first ? SUM_W'(r_s1_pix) : s1_old + SUM_W'(r_s1_pix);
    assign s1_sum = (r_s1_tstart ? '0 : r_acc) + AW'(s1_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_te    <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            r_s1_te    <= in_acc && tile_end;
            r_s2_valid <= r_s1_valid && r_s1_te;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr   <= r_col;
            r_s1_pix    <= i_pixel;
            r_s1_first  <= (r_rib == '0);
            r_s1_tstart <= (r_tcol == '0);
            r_s1_fwd    <= r_s1_valid && (r_s1_addr == r_col);
            r_s1_start  <= r_col - CW'(r_tcol);
            r_s1_len    <= TW'(r_tcol) + TW'(1);
            r_s1_rows   <= TW'(r_rib) + TW'(1);
            r_s1_row0   <= r_bsr;
        end
        if (r_s1_valid) begin
            r_wq <= s1_new;
        end
        if (r_s1_valid && r_s1_te) begin
            r_s2_sum   <= s1_sum;
            r_s2_lr    <= LW'(r_s1_len) * LW'(r_s1_rows);
            r_s2_start <= r_s1_start;
            r_s2_len   <= r_s1_len;
            r_s2_rows  <= r_s1_rows;
            r_s2_row0  <= r_s1_row0;
        end
    end

    // Pass test without a division: sum against threshold times pixel count.
    assign s2_pass = CMPW'(r_s2_sum) >= CMPW'(PW'(r_thr) * PW'(r_s2_lr));

    always_comb begin
        s2_desc.row0  = r_s2_row0;
        s2_desc.start = START_W'(r_s2_start);
        s2_desc.len   = LEN_W'(r_s2_len);
        s2_desc.rows  = r_s2_rows;
        s2_desc.pass  = s2_pass;
    end

    // ------------------------------------------------------------------
    // Descriptor queue and span emitter: one span per tile row.
    // ------------------------------------------------------------------
    assign head     = r_fifo[r_rp];
    assign out_free = !r_o_valid || !i_stall;
    assign em_go    = out_free && (r_fcnt != '0);
    assign em_last  = (TW'(r_em_r) + TW'(1) == head.rows);
    assign em_row   = head.row0 + ROW_W'(r_em_r);
    assign pop      = em_go && em_last;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_wp] <= s2_desc;
        end
        if (em_go) begin
            r_o_row   <= em_row;
            r_o_start <= head.start;
            r_o_len   <= head.len;
            r_o_level <= (head.pass && (em_row >= r_first_row)) ? PASS_LEVEL : FAIL_LEVEL;
            r_o_last  <= em_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_fcnt    <= '0;
            r_em_r    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_s2_valid) begin
                r_wp <= r_wp + FAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FAW'(1);
            end
            r_fcnt <= r_fcnt + FCW'(r_s2_valid) - FCW'(pop);
            if (em_go) begin
                r_em_r <= em_last ? '0 : r_em_r + RW'(1);
            end
            if (em_go) begin
                r_o_valid <= 1'b1;
            end else if (out_free) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_row     = r_o_row;
    assign o_span_start  = r_o_start;
    assign o_span_length = r_o_len;
    assign o_level       = r_o_level;
    assign o_last        = r_o_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `TMT_ASSERT_IMP(a_fifo_bound, 1'b1, 32'(r_fcnt) <= DESC_DEPTH)
    `TMT_ASSERT_IMP(a_tcol_in_tile, r_state == S_RUN, 32'(r_tcol) < 32'(ts_eff))
    `TMT_ASSERT_IMP(a_col_in_row, r_state == S_RUN, r_col <= w_m1)
    `TMT_ASSERT_NXT(a_div_to_sum, (r_state == S_DIV) && (r_div_cnt == '0) && !cfg_geom, r_state == S_SUM)

endmodule
